>>> src/glyph_atlas_shelf_packer_unit_assert.svh
// Assertion macros shared by the glyph atlas shelf packer checkers.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef GLYPH_ATLAS_SHELF_PACKER_UNIT_ASSERT_SVH
`define GLYPH_ATLAS_SHELF_PACKER_UNIT_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define GASP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("gasp assertion failed");

// Property checked on clock edges that fall while reset is applied.
`define GASP_ASSERT_RST(lbl, expr) \
	lbl: assert property (@(posedge clk) !arst_n |-> (expr)) \
		else $error("gasp reset assertion failed");

`endif

>>> src/gasp_pkg.sv
// Package for the glyph atlas shelf packer: widths, status codes, register indexes,
// states and the command, status and configuration structs. No dependencies.
package gasp_pkg;

	localparam int COORD_BITS = 16;
	localparam int CAP_INT    = (COORD_BITS >= 16) ? 65536 : (1 << COORD_BITS);

	localparam int GLYPH_W = 12;
	localparam int CELL_W  = 13;
	localparam int POS_W   = 16;
	localparam int DIM_W   = 17;
	localparam int NEED_W  = DIM_W + 1;
	localparam int GROW_W  = DIM_W + 2;
	localparam int SHELF_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 96;

	localparam logic [DIM_W-1:0] CAP = DIM_W'(CAP_INT);
	localparam logic [DIM_W-1:0] Y_SAT = {DIM_W{1'b1}};

	localparam logic [1:0] STAT_PLACED = 2'd0;
	localparam logic [1:0] STAT_SKIP   = 2'd1;
	localparam logic [1:0] STAT_NOROOM = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MARGIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PADDING = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_W   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_H   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_W  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_H  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MONO    = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_ACROSS,
		ST_WGROW,
		ST_DOWN,
		ST_HGROW,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [3:0]       margin;
		logic [3:0]       padding;
		logic [DIM_W-1:0] max_w;
		logic [DIM_W-1:0] max_h;
		logic [DIM_W-1:0] init_w;
		logic [DIM_W-1:0] init_h;
		logic             mono;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic across;
		logic wstep;
		logic down;
		logic hstep;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic over_w;
		logic over_h;
		logic n_short;
		logic out_free;
	} stat_t;

endpackage

>>> src/glyph_atlas_shelf_packer_unit.sv
// Top level of the glyph atlas shelf packer: configuration registers,
// controller and datapath. Depends on gasp_pkg, gasp_cfg, gasp_ctrl, gasp_dp.
//
//   Channel   Direction  Signals                          Payload
//   s_axis    in         s_axis_tvalid/tready/tdata[23:0]  glyph size
//   m_axis    out        m_axis_tvalid/tready/tdata[95:0]  placement result
//   cfg       in         cfg_wr_en, cfg_addr, cfg_wdata    register write
//
// With no growth a glyph passes from its transfer through sizing, width check, height
// check and result load (PREP, ACROSS, DOWN, DONE); the next transfer is taken only
// once that result is loaded. A zero-size glyph skips both checks. Each doubling of the
// atlas width or height is one step in the shared doubling register (WGROW or HGROW).
// A waiting result holds back the next result load and, with it, the next transfer.
// Reset clears the packing state and the atlas; no clearing pass is needed.
module glyph_atlas_shelf_packer_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// width[11:0], height[23:12]
	input  logic [gasp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// status[1:0], cell_x[17:2], cell_y[33:18], cell_width[46:34],
	// cell_height[59:47], texture_width[76:60], texture_height[93:77],
	// resized[94], zero[95]
	output logic [gasp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                            cfg_wr_en,
	input  logic [gasp_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [gasp_pkg::DIM_W-1:0]      cfg_wdata
);
	import gasp_pkg::*;

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	gasp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	gasp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gasp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

>>> src/gasp_cfg.sv
// Configuration register file of the glyph atlas shelf packer.
// Depends on gasp_pkg for the register indexes and the cfg_t struct.
module gasp_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [gasp_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [gasp_pkg::DIM_W-1:0]     cfg_wdata,
	output gasp_pkg::cfg_t                 cfg
);
	import gasp_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.margin  <= 4'd0;
			cfg_q.padding <= 4'd0;
			cfg_q.max_w   <= DIM_W'(2048);
			cfg_q.max_h   <= '0;
			cfg_q.init_w  <= DIM_W'(256);
			cfg_q.init_h  <= DIM_W'(32);
			cfg_q.mono    <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_MARGIN:  cfg_q.margin  <= cfg_wdata[3:0];
				REG_PADDING: cfg_q.padding <= cfg_wdata[3:0];
				REG_MAX_W:   cfg_q.max_w   <= cfg_wdata;
				REG_MAX_H:   cfg_q.max_h   <= cfg_wdata;
				REG_INIT_W:  cfg_q.init_w  <= cfg_wdata;
				REG_INIT_H:  cfg_q.init_h  <= cfg_wdata;
				REG_MONO:    cfg_q.mono    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> src/gasp_dp.sv
// Datapath of the glyph atlas shelf packer: cell sizing, packing state,
// the shared doubling unit for atlas growth and the output register.
// Depends on gasp_pkg; driven by gasp_ctrl through cmd_t and stat_t.
module gasp_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  gasp_pkg::cfg_t                  cfg,
	input  gasp_pkg::cmd_t                  cmd,
	output gasp_pkg::stat_t                 stat,
	input  logic [gasp_pkg::IN_DATA_W-1:0]  in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [gasp_pkg::OUT_DATA_W-1:0] out_data
);
	import gasp_pkg::*;

	logic [GLYPH_W-1:0] gw_q, gh_q;
	logic [CELL_W-1:0]  cw_q, ch_q;
	logic [1:0]         status_q;
	logic               resized_q;
	logic [NEED_W-1:0]  need_q;
	logic [GROW_W-1:0]  n_q;

	logic [DIM_W-1:0]   cursor_x_q, cursor_y_q, aw_q, ah_q;
	logic [SHELF_W-1:0] shelf_q;
	logic               started_q;
	logic               out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic [4:0]         m2, pad2;
	logic [CELL_W-1:0]  cw_raw, cw_new, ch_new;
	logic [SHELF_W-1:0] shelf_new, shelf_ch;
	logic               skip;
	logic [NEED_W-1:0]  need_w, need_h, y_sum;
	logic [GROW_W-1:0]  first_w, first_h;
	logic               n_short, w_ok, h_fail;
	logic               coord_sat, placed;
	logic [1:0]         final_status;
	logic [DIM_W-1:0]   seed_w, seed_h;
	logic [POS_W-1:0]   cx_out, cy_out;
	logic [CELL_W-1:0]  cw_out, ch_out;

	always_comb begin
		m2        = {cfg.margin, 1'b0};
		pad2      = {cfg.padding, 1'b0};
		skip      = (gw_q == '0) || (gh_q == '0);
		cw_raw    = CELL_W'(gw_q) + CELL_W'(m2) + CELL_W'(4);
		cw_new    = cfg.mono ? ((cw_raw + CELL_W'(7)) & ~CELL_W'(7)) : cw_raw;
		ch_new    = CELL_W'(gh_q) + CELL_W'(m2) + CELL_W'(4);
		shelf_new = SHELF_W'(ch_new) + SHELF_W'(m2);
		shelf_ch  = SHELF_W'(ch_q) + SHELF_W'(m2);
		seed_w    = (cfg.init_w == '0) ? DIM_W'(1) : ((cfg.init_w > CAP) ? CAP : cfg.init_w);
		seed_h    = (cfg.init_h == '0) ? DIM_W'(1) : ((cfg.init_h > CAP) ? CAP : cfg.init_h);
		need_w    = NEED_W'(cursor_x_q) + NEED_W'(cw_q);
		need_h    = NEED_W'(cursor_y_q) + NEED_W'(ch_q);
		y_sum     = NEED_W'(cursor_y_q) + NEED_W'(shelf_q) + NEED_W'(pad2);
		first_w   = (aw_q == '0) ? GROW_W'(1) : {1'b0, aw_q, 1'b0};
		first_h   = (ah_q == '0) ? GROW_W'(1) : {1'b0, ah_q, 1'b0};
		n_short   = n_q < GROW_W'(need_q);
		w_ok      = (n_q <= GROW_W'(cfg.max_w)) && (n_q <= GROW_W'(CAP));
		h_fail    = ((cfg.max_h != '0) && (n_q > GROW_W'(cfg.max_h))) ||
		            (n_q > GROW_W'(CAP));
		coord_sat = (cursor_x_q >= CAP) || (cursor_y_q >= CAP);
		final_status = ((status_q == STAT_PLACED) && coord_sat) ? STAT_NOROOM : status_q;
		placed    = final_status == STAT_PLACED;
		cx_out    = placed ? cursor_x_q[POS_W-1:0] : '0;
		cy_out    = placed ? cursor_y_q[POS_W-1:0] : '0;
		cw_out    = (status_q == STAT_SKIP) ? '0 : cw_q;
		ch_out    = (status_q == STAT_SKIP) ? '0 : ch_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			gw_q <= in_data[GLYPH_W-1:0];
			gh_q <= in_data[2*GLYPH_W-1:GLYPH_W];
		end
		if (cmd.prep) begin
			cw_q      <= cw_new;
			ch_q      <= ch_new;
			status_q  <= skip ? STAT_SKIP : STAT_PLACED;
			resized_q <= 1'b0;
		end
		if (cmd.across) begin
			need_q <= need_w;
			n_q    <= first_w;
		end
		if (cmd.down) begin
			need_q <= need_h;
			n_q    <= first_h;
		end
		if ((cmd.wstep || cmd.hstep) && n_short) begin
			n_q <= {n_q[GROW_W-2:0], 1'b0};
		end
		if (cmd.wstep && !n_short && w_ok) begin
			resized_q <= 1'b1;
		end
		if (cmd.hstep && !n_short) begin
			if (h_fail) begin
				status_q <= STAT_NOROOM;
			end else begin
				resized_q <= 1'b1;
			end
		end
		if (cmd.emit) begin
			out_data_q <= {1'b0, resized_q, ah_q, aw_q, ch_out, cw_out, cy_out, cx_out,
			               final_status};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q  <= '0;
			cursor_y_q  <= '0;
			shelf_q     <= '0;
			aw_q        <= '0;
			ah_q        <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.prep && !skip) begin
				if (!started_q) begin
					aw_q      <= seed_w;
					ah_q      <= seed_h;
					started_q <= 1'b1;
				end
				if (shelf_new > shelf_q) begin
					shelf_q <= shelf_new;
				end
			end
			if (cmd.wstep && !n_short) begin
				if (w_ok) begin
					aw_q <= n_q[DIM_W-1:0];
				end else begin
					cursor_x_q <= '0;
					cursor_y_q <= y_sum[NEED_W-1] ? Y_SAT : y_sum[DIM_W-1:0];
					shelf_q    <= shelf_ch;
				end
			end
			if (cmd.hstep && !n_short && !h_fail) begin
				ah_q <= n_q[DIM_W-1:0];
			end
			if (cmd.emit && placed) begin
				cursor_x_q <= cursor_x_q + DIM_W'(cw_q) + DIM_W'(pad2);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.skip     = skip;
	assign stat.over_w   = need_w > NEED_W'(aw_q);
	assign stat.over_h   = need_h > NEED_W'(ah_q);
	assign stat.n_short  = n_short;
	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_data      = out_data_q;

endmodule

>>> src/gasp_ctrl.sv
// Controller state machine of the glyph atlas shelf packer.
// Depends on gasp_pkg; sequences gasp_dp through cmd_t and reads stat_t.
module gasp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  gasp_pkg::stat_t stat,
	output gasp_pkg::cmd_t  cmd
);
	import gasp_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = stat.skip ? ST_DONE : ST_ACROSS;
			end
			ST_ACROSS: begin
				if (stat.over_w) begin
					cmd.across = 1'b1;
					state_d    = ST_WGROW;
				end else begin
					state_d = ST_DOWN;
				end
			end
			ST_WGROW: begin
				cmd.wstep = 1'b1;
				if (!stat.n_short) begin
					state_d = ST_DOWN;
				end
			end
			ST_DOWN: begin
				if (stat.over_h) begin
					cmd.down = 1'b1;
					state_d  = ST_HGROW;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_HGROW: begin
				cmd.hstep = 1'b1;
				if (!stat.n_short) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

>>> src/gasp_checker.sv
// Port-level checker for the glyph atlas shelf packer, bound to the top level.
// Depends on gasp_pkg and glyph_atlas_shelf_packer_unit_assert.svh.
`include "glyph_atlas_shelf_packer_unit_assert.svh"

module gasp_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic [gasp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [gasp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic                            cfg_wr_en,
	input logic [gasp_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input logic [gasp_pkg::DIM_W-1:0]      cfg_wdata
);
	import gasp_pkg::*;

	logic [1:0]       res_status;
	logic [57:0]      res_cell;
	logic [DIM_W-1:0] res_tex_w;
	logic [DIM_W-1:0] res_tex_h;

	assign res_status = m_axis_tdata[1:0];
	assign res_cell   = m_axis_tdata[59:2];
	assign res_tex_w  = m_axis_tdata[76:60];
	assign res_tex_h  = m_axis_tdata[93:77];

	`GASP_ASSERT_RST(a_no_result_in_reset, !m_axis_tvalid)
	`GASP_ASSERT(a_result_held, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
	`GASP_ASSERT(a_status_legal, m_axis_tvalid |-> res_status <= STAT_NOROOM)
	`GASP_ASSERT(a_skip_no_cell, m_axis_tvalid && res_status == STAT_SKIP |-> res_cell == '0)
	`GASP_ASSERT(a_placed_has_atlas, m_axis_tvalid && res_status == STAT_PLACED |-> res_tex_w != '0 && res_tex_h != '0)

endmodule

bind glyph_atlas_shelf_packer_unit gasp_checker u_gasp_checker (.*);

>>> verif/tb.sv
// Self-checking testbench for glyph_atlas_shelf_packer_unit: a directed table, whose checked
// rows carry typed results, then random register phases checked by an in-bench predictor.
// Depends on gasp_pkg and the RTL top level only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gasp_pkg::*;

	localparam int WIDE         = 40;
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_GLYPHS = 92;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int MAX_REPORTS  = 10;
	localparam int DIR_ROWS     = 33;

	typedef struct packed {
		logic              zero;
		logic              resized;
		logic [DIM_W-1:0]  tex_h;
		logic [DIM_W-1:0]  tex_w;
		logic [CELL_W-1:0] cell_h;
		logic [CELL_W-1:0] cell_w;
		logic [POS_W-1:0]  cell_y;
		logic [POS_W-1:0]  cell_x;
		logic [1:0]        status;
	} placement_t;

	typedef enum {ROW_CFG, ROW_GLYPH, ROW_CHECKED} row_kind_t;

	// For register rows a is the index and b the value; for glyph rows they are width and
	// height. The last eight fields hold the typed result of checked rows.
	typedef struct {
		row_kind_t kind;
		int        a;
		int        b;
		int        st;
		int        cx;
		int        cy;
		int        cw;
		int        ch;
		int        tw;
		int        th;
		int        rs;
	} dir_row_t;

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_CHECKED, 0, 0, STAT_SKIP, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CHECKED, 4095, 0, STAT_SKIP, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CHECKED, 0, 4095, STAT_SKIP, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CHECKED, 10, 10, STAT_PLACED, 0, 0, 14, 14, 256, 32, 0},
		'{ROW_GLYPH, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_MARGIN, 15, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_PADDING, 15, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_MONO, 1, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_GLYPH, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_GLYPH, 4095, 4095, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_GLYPH, 4095, 1, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_GLYPH, 1, 4095, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_GLYPH, 2730, 1365, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_GLYPH, 1365, 2730, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_MAX_W, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_GLYPH, 100, 100, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_GLYPH, 300, 7, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_GLYPH, 0, 5, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_MAX_H, 1, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_GLYPH, 4095, 4095, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_GLYPH, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_MARGIN, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_PADDING, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_MONO, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_MAX_W, 131071, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_MAX_H, 131071, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_GLYPH, 4095, 4095, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_GLYPH, 4095, 4095, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_GLYPH, 4095, 4095, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_GLYPH, 4095, 4095, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_INIT_W, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_INIT_H, 131071, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_GLYPH, 8, 8, 0, 0, 0, 0, 0, 0, 0, 0}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_addr;
	logic [DIM_W-1:0]      cfg_wdata;

	logic [3:0]       margin_q;
	logic [3:0]       padding_q;
	logic [DIM_W-1:0] max_w_q;
	logic [DIM_W-1:0] max_h_q;
	logic [DIM_W-1:0] init_w_q;
	logic [DIM_W-1:0] init_h_q;
	logic             mono_q;
	logic [WIDE-1:0]  cur_x;
	logic [WIDE-1:0]  cur_y;
	logic [WIDE-1:0]  shelf_h;
	logic [WIDE-1:0]  atl_w;
	logic [WIDE-1:0]  atl_h;
	logic             started;

	placement_t placements_due [$];
	placement_t got_res;
	placement_t want_res;

	int  src_idle_pct;
	int  snk_idle_pct;
	bit  hold_request;
	int  mismatches;
	int  glyphs_sent;
	int  results_seen;
	int  placed_cnt;
	int  skipped_cnt;
	int  noroom_cnt;
	int  resized_cnt;
	int  reg_phases;

	glyph_atlas_shelf_packer_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [WIDE-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		if (v == '0) begin
			return WIDE'(1);
		end
		return (WIDE'(v) > WIDE'(CAP_INT)) ? WIDE'(CAP_INT) : WIDE'(v);
	endfunction

	function automatic logic [WIDE-1:0] double_until(input logic [WIDE-1:0] cur,
		input logic [WIDE-1:0] need);
		logic [WIDE-1:0] n;
		n = cur << 1;
		if (n == '0) begin
			n = WIDE'(1);
		end
		while (n < need) begin
			n = n << 1;
		end
		return n;
	endfunction

	function automatic placement_t place_glyph(input logic [GLYPH_W-1:0] gw,
		input logic [GLYPH_W-1:0] gh);
		placement_t      res;
		logic [WIDE-1:0] cw;
		logic [WIDE-1:0] ch;
		logic [WIDE-1:0] m2;
		logic [WIDE-1:0] pad2;
		logic [WIDE-1:0] cap;
		logic [WIDE-1:0] grown;
		res  = '0;
		cap  = WIDE'(CAP_INT);
		m2   = WIDE'(margin_q) << 1;
		pad2 = WIDE'(padding_q) << 1;
		if (gw == '0 || gh == '0) begin
			res.status = STAT_SKIP;
			res.tex_w  = atl_w[DIM_W-1:0];
			res.tex_h  = atl_h[DIM_W-1:0];
			return res;
		end
		cw = WIDE'(gw) + m2 + WIDE'(4);
		ch = WIDE'(gh) + m2 + WIDE'(4);
		if (mono_q) begin
			cw = (cw + WIDE'(7)) & ~WIDE'(7);
		end
		if (!started) begin
			atl_w   = clamp_dim(init_w_q);
			atl_h   = clamp_dim(init_h_q);
			started = 1'b1;
		end
		if (ch + m2 > shelf_h) begin
			shelf_h = ch + m2;
		end
		res.status = STAT_PLACED;
		if (cur_x + cw > atl_w) begin
			grown = double_until(atl_w, cur_x + cw);
			if (grown <= WIDE'(max_w_q) && grown <= cap) begin
				atl_w       = grown;
				res.resized = 1'b1;
			end else begin
				cur_x   = '0;
				cur_y   = cur_y + shelf_h + pad2;
				shelf_h = ch + m2;
			end
		end
		if (cur_y + ch > atl_h) begin
			grown = double_until(atl_h, cur_y + ch);
			if ((max_h_q != '0 && grown > WIDE'(max_h_q)) || grown > cap) begin
				res.status = STAT_NOROOM;
			end else begin
				atl_h       = grown;
				res.resized = 1'b1;
			end
		end
		if (res.status == STAT_PLACED && (cur_x >= cap || cur_y >= cap)) begin
			res.status = STAT_NOROOM;
		end
		if (res.status == STAT_PLACED) begin
			res.cell_x = cur_x[POS_W-1:0];
			res.cell_y = cur_y[POS_W-1:0];
			cur_x      = cur_x + cw + pad2;
		end
		res.cell_w = cw[CELL_W-1:0];
		res.cell_h = ch[CELL_W-1:0];
		res.tex_w  = atl_w[DIM_W-1:0];
		res.tex_h  = atl_h[DIM_W-1:0];
		return res;
	endfunction

	// Mostly small glyphs so that shelves fill up slowly, with zero sizes and a few
	// very large ones mixed in.
	function automatic logic [2*GLYPH_W-1:0] random_glyph();
		logic [GLYPH_W-1:0] w;
		logic [GLYPH_W-1:0] h;
		int                 sel;
		sel = $urandom_range(0, 99);
		w   = GLYPH_W'($urandom_range(1, 40));
		h   = GLYPH_W'($urandom_range(1, 40));
		if (sel < 6) begin
			if (sel[0]) begin
				w = '0;
			end else begin
				h = '0;
			end
		end else if (sel < 9) begin
			if (sel[0]) begin
				w = GLYPH_W'($urandom_range(2048, 4095));
			end else begin
				h = GLYPH_W'($urandom_range(2048, 4095));
			end
		end else if (sel < 24) begin
			w = GLYPH_W'($urandom_range(1, 600));
			h = GLYPH_W'($urandom_range(1, 300));
		end
		return {h, w};
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS) begin
				$display("mismatch in result %0d, %s: expected %0d, actual %0d",
					results_seen, name, want, got);
			end
		end
	endtask

	task automatic send_glyph(input logic [GLYPH_W-1:0] w, input logic [GLYPH_W-1:0] h,
		input bit typed, input placement_t typed_res);
		placement_t predicted;
		if (src_idle_pct > 0 && $urandom_range(1, 100) <= src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		s_axis_tdata  <= {h, w};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		predicted = place_glyph(w, h);
		placements_due.push_back(typed ? typed_res : predicted);
		glyphs_sent++;
		@(negedge clk);
	endtask

	// Drops the stream and waits until every accepted glyph has produced its result.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (placements_due.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] v);
		cfg_addr  <= idx;
		cfg_wdata <= v;
		cfg_wr_en <= 1'b1;
		case (idx)
			REG_MARGIN:  margin_q  = v[3:0];
			REG_PADDING: padding_q = v[3:0];
			REG_MAX_W:   max_w_q   = v;
			REG_MAX_H:   max_h_q   = v;
			REG_INIT_W:  init_w_q  = v;
			REG_INIT_H:  init_h_q  = v;
			REG_MONO:    mono_q    = v[0];
			default:     ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int stall_left;
		stall_left    = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left   = LONG_HOLD;
			end
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else if (snk_idle_pct > 0 && $urandom_range(1, 100) <= snk_idle_pct) begin
				m_axis_tready <= 1'b0;
				stall_left = $urandom_range(0, 12);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_res = placement_t'(m_axis_tdata);
			if (placements_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("unexpected result %0d: status %0d x %0d y %0d", results_seen,
						got_res.status, got_res.cell_x, got_res.cell_y);
				end
			end else begin
				want_res = placements_due.pop_front();
				check_field("status", want_res.status, got_res.status);
				check_field("cell_x", want_res.cell_x, got_res.cell_x);
				check_field("cell_y", want_res.cell_y, got_res.cell_y);
				check_field("cell_width", want_res.cell_w, got_res.cell_w);
				check_field("cell_height", want_res.cell_h, got_res.cell_h);
				check_field("texture_width", want_res.tex_w, got_res.tex_w);
				check_field("texture_height", want_res.tex_h, got_res.tex_h);
				check_field("resized", want_res.resized, got_res.resized);
				check_field("spare bit", want_res.zero, got_res.zero);
			end
			if (got_res.status == STAT_PLACED) begin
				placed_cnt++;
			end else if (got_res.status == STAT_SKIP) begin
				skipped_cnt++;
			end else begin
				noroom_cnt++;
			end
			if (got_res.resized) begin
				resized_cnt++;
			end
			results_seen++;
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d results still due", CYCLE_LIMIT,
			placements_due.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		placement_t       typed_res;
		logic [GLYPH_W*2-1:0] glyph;
		logic [DIM_W-1:0] reg_vals [REG_MONO+1];
		logic [DIM_W-1:0] width_picks [7];
		logic [DIM_W-1:0] height_picks [7];
		int               idle_levels [4];
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_wr_en     = 1'b0;
		cfg_addr      = '0;
		cfg_wdata     = '0;
		src_idle_pct  = 10;
		snk_idle_pct  = 10;
		hold_request  = 1'b0;
		margin_q      = 4'd0;
		padding_q     = 4'd0;
		max_w_q       = DIM_W'(2048);
		max_h_q       = '0;
		init_w_q      = DIM_W'(256);
		init_h_q      = DIM_W'(32);
		mono_q        = 1'b0;
		cur_x         = '0;
		cur_y         = '0;
		shelf_h       = '0;
		atl_w         = '0;
		atl_h         = '0;
		started       = 1'b0;
		idle_levels   = '{0, 5, 15, 30};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[k]) begin
			if (dir_rows[k].kind == ROW_CFG) begin
				settle();
				write_reg(CFG_IDX_W'(dir_rows[k].a), DIM_W'(dir_rows[k].b));
			end else begin
				typed_res         = '0;
				typed_res.status  = 2'(dir_rows[k].st);
				typed_res.cell_x  = POS_W'(dir_rows[k].cx);
				typed_res.cell_y  = POS_W'(dir_rows[k].cy);
				typed_res.cell_w  = CELL_W'(dir_rows[k].cw);
				typed_res.cell_h  = CELL_W'(dir_rows[k].ch);
				typed_res.tex_w   = DIM_W'(dir_rows[k].tw);
				typed_res.tex_h   = DIM_W'(dir_rows[k].th);
				typed_res.resized = dir_rows[k].rs[0];
				send_glyph(GLYPH_W'(dir_rows[k].a), GLYPH_W'(dir_rows[k].b),
					dir_rows[k].kind == ROW_CHECKED, typed_res);
			end
		end

		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			settle();
			width_picks  = '{'0, DIM_W'(1), DIM_W'(64), DIM_W'(2048), DIM_W'(65536),
				'1, DIM_W'($urandom_range(1, 65536))};
			height_picks = '{'0, DIM_W'(1), DIM_W'(4096), DIM_W'(65536), '1,
				DIM_W'($urandom_range(1, 65536)), '0};
			reg_vals[REG_MARGIN]  = phase[0] ? DIM_W'(15) : DIM_W'($urandom_range(0, 15));
			reg_vals[REG_PADDING] = phase[1] ? '0 : DIM_W'($urandom_range(0, 15));
			reg_vals[REG_MAX_W]   = width_picks[$urandom_range(0, 6)];
			reg_vals[REG_MAX_H]   = height_picks[$urandom_range(0, 6)];
			reg_vals[REG_INIT_W]  = DIM_W'($urandom);
			reg_vals[REG_INIT_H]  = DIM_W'($urandom);
			reg_vals[REG_MONO]    = DIM_W'($urandom_range(0, 1));
			for (int r = 0; r <= REG_MONO; r++) begin
				write_reg(CFG_IDX_W'(r), reg_vals[r]);
			end
			reg_phases++;
			if (phase == RAND_PHASES - 1) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end else begin
				src_idle_pct = idle_levels[$urandom_range(0, 3)];
				snk_idle_pct = idle_levels[$urandom_range(0, 3)];
			end
			if (phase == 2) begin
				hold_request = 1'b1;
				src_idle_pct = 0;
			end
			repeat (PHASE_GLYPHS) begin
				glyph = random_glyph();
				send_glyph(glyph[GLYPH_W-1:0], glyph[2*GLYPH_W-1:GLYPH_W], 1'b0, '0);
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d glyphs over %0d random register phases; %0d results checked.",
			glyphs_sent, reg_phases, results_seen);
		$display("Outcomes: %0d placed, %0d skipped, %0d out of room, %0d with growth.",
			placed_cnt, skipped_cnt, noroom_cnt, resized_cnt);
		if (mismatches == 0 && placements_due.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
